[hw/rtl/signature_dual_fixed_point_unit_assert.svh]
// ----------------------------------------------------------------------------
// Signature offset unit assertion macros
// Property shorthands for the port checker; they use clk and arst_n by name.
// ----------------------------------------------------------------------------
`ifndef SIGNATURE_DUAL_FIXED_POINT_UNIT_ASSERT_SVH
`define SIGNATURE_DUAL_FIXED_POINT_UNIT_ASSERT_SVH

// consequent in the same cycle
`define SDF_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("offset unit port check failed");

// consequent in the next cycle
`define SDF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("offset unit port check failed");

`endif

[hw/rtl/sdf_pkg.sv]
// ----------------------------------------------------------------------------
// Signature offset unit package
// Field widths, command codes, item types and sequencer states.
// ----------------------------------------------------------------------------
package sdf_pkg;

	localparam int MAX_DIM_DEF    = 16;
	localparam int MAX_PASSES_DEF = 32;

	localparam int IDX_W  = 4;
	localparam int VAL_W  = 16;
	localparam int OFS_W  = 22;
	localparam int DIM_W  = 5;
	localparam int FUNC_W = 2;

	localparam logic [OFS_W-1:0] OFS_TOP   = '1;
	localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

	localparam logic [FUNC_W-1:0] FUNC_ENTRY  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ASSIGN = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RUN    = 2'd2;

	localparam logic [1:0] REG_C = 2'd0;
	localparam logic [1:0] REG_D = 2'd1;
	localparam logic [1:0] REG_A = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [VAL_W-1:0]  entry_value;
		logic              present;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic             kind;
		logic [OFS_W-1:0] offset_value;
		logic             not_converged;
		logic             last;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ZERO,
		ST_PA,
		ST_PB0,
		ST_PB1,
		ST_PEND,
		ST_EMIT
	} state_t;

endpackage

[hw/rtl/signature_dual_fixed_point_unit.sv]
// ----------------------------------------------------------------------------
// Signature offset fixed point unit
// Loads a sparse signature matrix and a row assignment, then iterates the
// equation and variable offsets to their fixed point and emits them.
//
// channel   handshake              payload
// -------   ---------------------  ---------------------------------------
// command   start / busy           cmd (func, row, col, entry_value, present)
// result    strobe                 result (index, kind, offset_value, ...)
// config    cfg_we                 cfg_data (dimension)
//
// Load items (entry, assignment, unknown) are taken while idle and keep it idle.
// A run zeroes the offsets, then repeats passes (variable offsets from the present
// cells, then equation offsets) until none changes or MAX_PASSES passes are done,
// then emits the equation offsets and then the variable offsets.
// After reset the entry store is swept absent.
// Results are never held back; busy is high during the run but low at the last result.
// ----------------------------------------------------------------------------
module signature_dual_fixed_point_unit import sdf_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int MAX_PASSES = MAX_PASSES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cmd_t             cmd,
	output logic             strobe,
	output result_t          result,
	input  logic             cfg_we,
	input  logic [DIM_W-1:0] cfg_data
);

	logic [DIM_W-1:0] dim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_RESET;
		end else if (cfg_we) begin
			dim_q <= cfg_data;
		end
	end

	sdf_seq #(
		.MAX_DIM    (MAX_DIM),
		.MAX_PASSES (MAX_PASSES)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.dim    (dim_q),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

endmodule

[hw/rtl/sdf_entry_mem.sv]
// ----------------------------------------------------------------------------
// Signature entry store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sdf_entry_mem #(
	parameter int AW = 8,
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/sdf_ofs_mem.sv]
// ----------------------------------------------------------------------------
// Offset store
// Equation offsets, variable offsets and assigned columns. One write port,
// two registered read ports that return the data written in the same cycle.
// ----------------------------------------------------------------------------
module sdf_ofs_mem #(
	parameter int AW = 6,
	parameter int DW = 22
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] ra_addr,
	output logic [DW-1:0] ra_data,
	input  logic [AW-1:0] rb_addr,
	output logic [DW-1:0] rb_data
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_data <= (we && waddr == ra_addr) ? wdata : mem[ra_addr];
		rb_data <= (we && waddr == rb_addr) ? wdata : mem[rb_addr];
	end

endmodule

[hw/rtl/sdf_seq.sv]
// ----------------------------------------------------------------------------
// Signature offset sequencer
// Walks the entry store and the offset store for clear, load, zero, pass and emit steps.
// ----------------------------------------------------------------------------
module sdf_seq import sdf_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int MAX_PASSES = MAX_PASSES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cmd_t             cmd,
	input  logic [DIM_W-1:0] dim,
	output logic             busy,
	output logic             strobe,
	output result_t          result
);

	localparam int IW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int EAW  = 2 * IW;
	localparam int OAW  = IW + 2;
	localparam int EW   = VAL_W + 1;
	localparam int NCAP = (MAX_DIM < 16) ? MAX_DIM : 16;
	localparam int PW   = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;

	state_t state_q, state_d;

	logic [EAW-1:0] clr_q;
	logic [IW:0]    zc_q;
	logic [IW-1:0]  i_q, j_q, nm1_q;
	logic           kind_q;
	logic [PW-1:0]  pass_q;
	logic           chg_q, nc_q;

	logic           a_vld_s1, b_vld_s1, e_vld_s1;
	logic [IW-1:0]  j_s1, i_s1, e_idx_s1;
	logic           aok_s1, e_kind_s1, e_last_s1;

	logic           ent_we;
	logic [EAW-1:0] ent_waddr, ent_raddr;
	logic [EW-1:0]  ent_wdata, ent_rdata;
	logic           ofs_we;
	logic [OAW-1:0] ofs_waddr, ofs_ra_addr, ofs_rb_addr;
	logic [OFS_W-1:0] ofs_wdata, ofs_ra_data, ofs_rb_data;

	logic             accept, run_go, row_ok, col_ok, a_ok;
	logic [DIM_W-1:0] n_run;
	logic [IW-1:0]    row_ix, col_ix, a_ix;
	logic [IDX_W-1:0] a4;
	logic             i_last, j_last, pass_done, chg_fin;
	logic [VAL_W-1:0] sig;
	logic [OFS_W-1:0] diff, dv, c_new;
	logic [VAL_W-1:0] sb;
	logic [OFS_W:0]   sum;
	logic             d_upd, b_chg;

	sdf_entry_mem #(.AW(EAW), .DW(EW)) u_entry (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	sdf_ofs_mem #(.AW(OAW), .DW(OFS_W)) u_ofs (
		.clk     (clk),
		.we      (ofs_we),
		.waddr   (ofs_waddr),
		.wdata   (ofs_wdata),
		.ra_addr (ofs_ra_addr),
		.ra_data (ofs_ra_data),
		.rb_addr (ofs_rb_addr),
		.rb_data (ofs_rb_data)
	);

	assign accept = start && (state_q == ST_IDLE);
	assign n_run  = (dim > DIM_W'(NCAP)) ? DIM_W'(NCAP) : dim;
	assign run_go = accept && (cmd.func == FUNC_RUN) && (n_run != '0);
	assign row_ok = int'(cmd.row) < MAX_DIM;
	assign col_ok = int'(cmd.col) < MAX_DIM;
	assign row_ix = IW'(cmd.row);
	assign col_ix = IW'(cmd.col);

	assign a4   = ofs_rb_data[IDX_W-1:0];
	assign a_ok = int'(a4) < MAX_DIM;
	assign a_ix = IW'(a4);

	assign i_last = (i_q == nm1_q);
	assign j_last = (j_q == nm1_q);

	// d update: max(d, c - sigma) over present cells
	assign sig   = ent_rdata[VAL_W-1:0];
	assign diff  = ofs_rb_data - OFS_W'(sig);
	assign d_upd = a_vld_s1 && ent_rdata[VAL_W] && (ofs_rb_data >= OFS_W'(sig))
		&& (diff > ofs_ra_data);

	// c update: d of the assigned column plus its sigma, saturated
	assign dv    = aok_s1 ? ofs_ra_data : '0;
	assign sb    = (aok_s1 && ent_rdata[VAL_W]) ? sig : '0;
	assign sum   = {1'b0, dv} + (OFS_W+1)'(sb);
	assign c_new = sum[OFS_W] ? OFS_TOP : sum[OFS_W-1:0];
	assign b_chg = (c_new != ofs_rb_data);

	assign chg_fin   = chg_q || (b_vld_s1 && b_chg);
	assign pass_done = !chg_fin || (pass_q == PW'(MAX_PASSES - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (&clr_q) state_d = ST_IDLE;
			ST_IDLE:  if (run_go) state_d = ST_ZERO;
			ST_ZERO:  if (&zc_q) state_d = ST_PA;
			ST_PA:    if (i_last && j_last) state_d = ST_PB0;
			ST_PB0:   state_d = ST_PB1;
			ST_PB1:   state_d = i_last ? ST_PEND : ST_PB0;
			ST_PEND:  state_d = pass_done ? ST_EMIT : ST_PA;
			ST_EMIT:  if (i_last && kind_q) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ent_we      = 1'b0;
		ent_waddr   = {row_ix, col_ix};
		ent_wdata   = {cmd.present, cmd.entry_value};
		ent_raddr   = {i_q, j_q};
		ofs_ra_addr = {REG_D, j_q};
		ofs_rb_addr = {REG_C, i_q};
		ofs_we      = 1'b0;
		ofs_waddr   = {REG_D, j_s1};
		ofs_wdata   = diff;
		case (state_q)
			ST_CLEAR: begin
				ent_we    = 1'b1;
				ent_waddr = clr_q;
				ent_wdata = '0;
			end
			ST_IDLE: begin
				ent_we    = accept && (cmd.func == FUNC_ENTRY) && row_ok && col_ok;
				ofs_we    = accept && (cmd.func == FUNC_ASSIGN) && row_ok;
				ofs_waddr = {REG_A, row_ix};
				ofs_wdata = OFS_W'(cmd.col);
			end
			ST_ZERO: begin
				ofs_we    = 1'b1;
				ofs_waddr = {1'b0, zc_q};
				ofs_wdata = '0;
			end
			ST_PB0: ofs_rb_addr = {REG_A, i_q};
			ST_PB1: begin
				ent_raddr   = {i_q, a_ix};
				ofs_ra_addr = {REG_D, a_ix};
			end
			ST_EMIT: ofs_ra_addr = {(kind_q ? REG_D : REG_C), i_q};
			default: ;
		endcase
		if (a_vld_s1) begin
			ofs_we    = d_upd;
			ofs_waddr = {REG_D, j_s1};
			ofs_wdata = diff;
		end else if (b_vld_s1) begin
			ofs_we    = 1'b1;
			ofs_waddr = {REG_C, i_s1};
			ofs_wdata = c_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			zc_q     <= '0;
			i_q      <= '0;
			j_q      <= '0;
			nm1_q    <= '0;
			kind_q   <= 1'b0;
			pass_q   <= '0;
			chg_q    <= 1'b0;
			nc_q     <= 1'b0;
			a_vld_s1 <= 1'b0;
			b_vld_s1 <= 1'b0;
			e_vld_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			a_vld_s1 <= (state_q == ST_PA);
			b_vld_s1 <= (state_q == ST_PB1);
			e_vld_s1 <= (state_q == ST_EMIT);
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					if (run_go) begin
						nm1_q <= IW'(n_run - 1'b1);
						zc_q  <= '0;
					end
				end
				ST_ZERO: begin
					zc_q <= zc_q + 1'b1;
					if (&zc_q) begin
						i_q    <= '0;
						j_q    <= '0;
						pass_q <= '0;
						chg_q  <= 1'b0;
					end
				end
				ST_PA: begin
					if (j_last) begin
						j_q <= '0;
						i_q <= i_last ? '0 : i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_PB0: begin
					if (b_vld_s1 && b_chg) begin
						chg_q <= 1'b1;
					end
				end
				ST_PB1: i_q <= i_last ? '0 : i_q + 1'b1;
				ST_PEND: begin
					if (pass_done) begin
						nc_q   <= chg_fin;
						kind_q <= 1'b0;
					end else begin
						pass_q <= pass_q + 1'b1;
						chg_q  <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (i_last) begin
						i_q    <= '0;
						kind_q <= 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		j_s1      <= j_q;
		i_s1      <= i_q;
		aok_s1    <= a_ok;
		e_idx_s1  <= i_q;
		e_kind_s1 <= kind_q;
		e_last_s1 <= kind_q && i_last;
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = e_vld_s1;

	always_comb begin
		result.index         = IDX_W'(e_idx_s1);
		result.kind          = e_kind_s1;
		result.offset_value  = ofs_ra_data;
		result.not_converged = nc_q;
		result.last          = e_last_s1;
	end

endmodule

[hw/rtl/sdf_chk.sv]
// ----------------------------------------------------------------------------
// Signature offset unit port checker
// Watches the top level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "signature_dual_fixed_point_unit_assert.svh"

module sdf_chk import sdf_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input cmd_t             cmd,
	input logic             strobe,
	input result_t          result,
	input logic             cfg_we,
	input logic [DIM_W-1:0] cfg_data
);

	logic load_acc;

	assign load_acc = start && !busy && (cmd.func != FUNC_RUN) && !cfg_we
		&& (cfg_data == cfg_data);

	`SDF_ASSERT_NEXT(a_load_stays_idle, load_acc, !busy && !strobe)
	`SDF_ASSERT_NEXT(a_last_ends_run, strobe && result.last, !strobe)
	`SDF_ASSERT_SAME(a_mid_run_busy, strobe && !result.last, busy)
	`SDF_ASSERT_SAME(a_flag_steady, strobe && $past(strobe), result.not_converged == $past(result.not_converged))

endmodule

bind signature_dual_fixed_point_unit sdf_chk u_sdf_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.cmd      (cmd),
	.strobe   (strobe),
	.result   (result),
	.cfg_we   (cfg_we),
	.cfg_data (cfg_data)
);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Signature offset unit testbench
// Loads signature entries and row assignments into the unit, then runs the
// offset fixed point under several dimension settings. Every run is replayed
// on a behavioral copy of the offset iteration, and each emitted offset is
// compared field by field with the oldest predicted one. Commands arrive in
// bursts with random gaps.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sdf_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
	localparam int NDIM = MAX_DIM_DEF;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             start    = 1'b0;
	logic             busy;
	cmd_t             cmd      = '0;
	logic             strobe;
	result_t          result;
	logic             cfg_we   = 1'b0;
	logic [DIM_W-1:0] cfg_data = '0;

	cmd_t    pending[$];
	result_t offset_expect[$];
	int      errors     = 0;
	logic    took       = 1'b0;
	int      burst_left = 0;
	int      gap_left   = 0;
	int      item_count = 0;

	logic [VAL_W-1:0] sig_val     [NDIM][NDIM];
	logic             sig_present [NDIM][NDIM];
	logic [IDX_W-1:0] row_col     [NDIM];
	int unsigned      eq_ofs      [NDIM];
	int unsigned      var_ofs     [NDIM];
	logic [DIM_W-1:0] dim_reg;

	int plan_col [NDIM];
	bit plan_set [NDIM];

	signature_dual_fixed_point_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.strobe   (strobe),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	function automatic void predict_offsets();
		int          n;
		int unsigned s;
		int unsigned a;
		int unsigned nc;
		bit          moved;
		result_t     r;
		n = (dim_reg > NDIM) ? NDIM : int'(dim_reg);
		moved = 1'b0;
		for (int i = 0; i < NDIM; i++) begin
			eq_ofs[i] = 0;
			var_ofs[i] = 0;
		end
		for (int p = 0; p < MAX_PASSES_DEF; p++) begin
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++)
					if (sig_present[i][j] && eq_ofs[i] >= sig_val[i][j]) begin
						a = eq_ofs[i] - sig_val[i][j];
						if (a > var_ofs[j])
							var_ofs[j] = a;
					end
			moved = 1'b0;
			for (int i = 0; i < n; i++) begin
				s = sig_present[i][row_col[i]] ? sig_val[i][row_col[i]] : 0;
				nc = var_ofs[row_col[i]] + s;
				if (nc > OFS_TOP)
					nc = 32'(OFS_TOP);
				if (nc != eq_ofs[i])
					moved = 1'b1;
				eq_ofs[i] = nc;
			end
			if (!moved)
				break;
		end
		for (int k = 0; k < 2; k++)
			for (int i = 0; i < n; i++) begin
				r.index = IDX_W'(i);
				r.kind = (k == 1);
				r.offset_value = OFS_W'((k == 1) ? var_ofs[i] : eq_ofs[i]);
				r.not_converged = moved;
				r.last = (k == 1 && i == n - 1);
				offset_expect = {offset_expect, r};
			end
	endfunction

	function automatic void apply_cmd(input cmd_t c);
		case (c.func)
			FUNC_ENTRY: begin
				sig_present[c.row][c.col] = c.present;
				sig_val[c.row][c.col] = c.present ? c.entry_value : '0;
			end
			FUNC_ASSIGN: begin
				row_col[c.row] = c.col;
			end
			FUNC_RUN: begin
				predict_offsets();
			end
			default: begin
			end
		endcase
	endfunction

	task automatic check_field(input string name, input logic [31:0] got_v,
			input logic [31:0] want_v, input result_t want);
		if (got_v !== want_v)
			report_mismatch($sformatf("%s of kind %0d index %0d: got %0d, expected %0d",
				name, want.kind, want.index, got_v, want_v));
	endtask

	task automatic check_offset(input result_t got);
		result_t want;
		if (offset_expect.size() == 0) begin
			report_mismatch($sformatf("unexpected offset: kind %0d index %0d value %0d",
				got.kind, got.index, got.offset_value));
			return;
		end
		want = offset_expect.pop_front();
		check_field("index", 32'(got.index), 32'(want.index), want);
		check_field("kind", 32'(got.kind), 32'(want.kind), want);
		check_field("offset_value", 32'(got.offset_value), 32'(want.offset_value), want);
		check_field("not_converged", 32'(got.not_converged), 32'(want.not_converged), want);
		check_field("last", 32'(got.last), 32'(want.last), want);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			took <= 1'b0;
			dim_reg = DIM_RESET;
			for (int i = 0; i < NDIM; i++) begin
				row_col[i] = '0;
				for (int j = 0; j < NDIM; j++) begin
					sig_present[i][j] = 1'b0;
					sig_val[i][j] = '0;
				end
			end
		end else begin
			took <= start && !busy;
			if (cfg_we)
				dim_reg = cfg_data;
			if (start && !busy)
				apply_cmd(cmd);
			if (strobe)
				check_offset(result);
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took) begin
			// hold until accepted
		end else if (gap_left > 0 || pending.size() == 0) begin
			start <= 1'b0;
			cmd <= cmd_t'($urandom);
			if (gap_left > 0)
				gap_left--;
		end else begin
			start <= 1'b1;
			cmd <= pending.pop_front();
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 15);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			end
		end
	end

	function automatic void push_item(input logic [FUNC_W-1:0] f, input int r, input int c,
			input int v, input bit p);
		cmd_t it;
		it.func = f;
		it.row = IDX_W'(r);
		it.col = IDX_W'(c);
		it.entry_value = VAL_W'(v);
		it.present = p;
		pending = {pending, it};
		if (f == FUNC_ASSIGN) begin
			plan_col[it.row] = int'(it.col);
			plan_set[it.row] = 1'b1;
		end
		if (f != FUNC_NONE)
			item_count++;
	endfunction

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending.size() != 0 || start || offset_expect.size() != 0 || busy);
		repeat (16) @(negedge clk);
	endtask

	task automatic begin_phase(input logic [DIM_W-1:0] dim);
		wait_idle();
		cfg_data <= dim;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_group(input int n);
		int hi;
		int r;
		int c;
		hi = (n == 0) ? NDIM - 1 : n - 1;
		for (int i = 0; i < n; i++)
			if (!plan_set[i] || $urandom_range(0, 2) == 0)
				push_item(FUNC_ASSIGN, i,
					($urandom_range(0, 4) == 0) ? $urandom_range(0, NDIM - 1)
						: $urandom_range(0, hi),
					$urandom, 1'($urandom));
		repeat ($urandom_range(2, 10)) begin
			r = $urandom_range(0, hi);
			c = ($urandom_range(0, 2) == 0 && r < n) ? plan_col[r] : $urandom_range(0, hi);
			if ($urandom_range(0, 9) == 0) begin
				r = $urandom_range(0, NDIM - 1);
				c = $urandom_range(0, NDIM - 1);
			end
			push_item(FUNC_ENTRY, r, c,
				($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4),
				$urandom_range(0, 4) != 0);
		end
		if ($urandom_range(0, 4) == 0)
			push_item(FUNC_NONE, $urandom, $urandom, $urandom, 1'($urandom));
		push_item(FUNC_RUN, $urandom, $urandom, $urandom, 1'($urandom));
	endtask

	initial begin
		int dims[7] = '{1, 16, 0, 31, 2, 17, 8};
		int d;
		int phase;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		begin_phase(5'd4);
		push_item(FUNC_ASSIGN, 0, 0, 0, 0);
		push_item(FUNC_ASSIGN, 1, 1, 0, 0);
		push_item(FUNC_ASSIGN, 2, 3, 0, 0);
		push_item(FUNC_ASSIGN, 3, 7, 0, 0);
		push_item(FUNC_ENTRY, 0, 0, 5, 1);
		push_item(FUNC_ENTRY, 1, 1, 65535, 1);
		push_item(FUNC_ENTRY, 2, 3, 65535, 0);
		push_item(FUNC_ENTRY, 3, 7, 3, 1);
		push_item(FUNC_ENTRY, 2, 0, 9, 1);
		push_item(FUNC_ENTRY, 0, 2, 2, 1);
		push_item(FUNC_ENTRY, 15, 15, 65535, 1);
		push_item(FUNC_NONE, 15, 15, 65535, 1);
		push_item(FUNC_RUN, 0, 0, 0, 0);
		push_item(FUNC_ENTRY, 0, 1, 0, 1);
		push_item(FUNC_ENTRY, 1, 0, 0, 1);
		push_item(FUNC_RUN, 15, 15, 65535, 1);
		push_item(FUNC_ENTRY, 1, 0, 0, 0);
		push_item(FUNC_RUN, 0, 0, 0, 0);

		phase = 0;
		while (item_count < 205) begin
			if (phase < 7)
				d = dims[phase];
			else
				d = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(0, 31);
			phase++;
			begin_phase(DIM_W'(d));
			repeat ($urandom_range(1, 2))
				random_group((d > NDIM) ? NDIM : d);
		end

		wait_idle();
		repeat (48) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[signature_dual_fixed_point_unit.f]
+incdir+hw/rtl
hw/rtl/sdf_pkg.sv
hw/rtl/sdf_entry_mem.sv
hw/rtl/sdf_ofs_mem.sv
hw/rtl/sdf_seq.sv
hw/rtl/signature_dual_fixed_point_unit.sv
hw/rtl/sdf_chk.sv
tb/testbench.sv
